/* hdl/tiralu_pkg.sv */
// ============================================================================
// tiralu_pkg
// Shared types, command codes and helpers for the typed register-file ALU.
// ============================================================================
`default_nettype none

package tiralu_pkg;

    localparam int NUM_REGS  = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_BITS  = $clog2(NUM_REGS);

    localparam logic [5:0] CMD_ADD   = 6'd0;
    localparam logic [5:0] CMD_SUB   = 6'd1;
    localparam logic [5:0] CMD_SUBR  = 6'd2;
    localparam logic [5:0] CMD_MUL   = 6'd3;
    localparam logic [5:0] CMD_MULU  = 6'd4;
    localparam logic [5:0] CMD_DIV   = 6'd5;
    localparam logic [5:0] CMD_DIVR  = 6'd6;
    localparam logic [5:0] CMD_DIVU  = 6'd7;
    localparam logic [5:0] CMD_DIVUR = 6'd8;
    localparam logic [5:0] CMD_MOD   = 6'd9;
    localparam logic [5:0] CMD_MODU  = 6'd10;
    localparam logic [5:0] CMD_AND   = 6'd11;
    localparam logic [5:0] CMD_OR    = 6'd12;
    localparam logic [5:0] CMD_XOR   = 6'd13;
    localparam logic [5:0] CMD_SHL   = 6'd14;
    localparam logic [5:0] CMD_SHLU  = 6'd15;
    localparam logic [5:0] CMD_SHR   = 6'd16;
    localparam logic [5:0] CMD_SHRU  = 6'd17;
    localparam logic [5:0] CMD_MOV   = 6'd18;
    localparam logic [5:0] CMD_CVTC  = 6'd19;
    localparam logic [5:0] CMD_CVTUC = 6'd20;
    localparam logic [5:0] CMD_CVTS  = 6'd21;
    localparam logic [5:0] CMD_CVTUS = 6'd22;
    localparam logic [5:0] CMD_CVTI  = 6'd23;
    localparam logic [5:0] CMD_CVTUI = 6'd24;
    localparam logic [5:0] CMD_NOT   = 6'd25;
    localparam logic [5:0] CMD_LDI   = 6'd26;
    localparam logic [5:0] CMD_CHE   = 6'd27;
    localparam logic [5:0] CMD_CHL   = 6'd28;
    localparam logic [5:0] CMD_CHLE  = 6'd29;
    localparam logic [5:0] CMD_CHB   = 6'd30;
    localparam logic [5:0] CMD_CHBE  = 6'd31;
    localparam logic [5:0] CMD_SET   = 6'd32;
    localparam logic [5:0] CMD_CLEAR = 6'd33;

    localparam logic [2:0] MODE_CHAR   = 3'd0;
    localparam logic [2:0] MODE_SHORT  = 3'd1;
    localparam logic [2:0] MODE_INT    = 3'd2;
    localparam logic [2:0] MODE_FLOAT  = 3'd5;
    localparam logic [2:0] MODE_DOUBLE = 3'd6;
    localparam logic [2:0] MODE_REF    = 3'd7;

    typedef struct packed {
        logic [5:0]  command;
        logic        use_immediate;
        logic [2:0]  mode;
        logic [5:0]  src_a;
        logic [5:0]  src_b;
        logic [5:0]  dest;
        logic [31:0] imm_b;
        logic [2:0]  imm_b_type;
        logic [31:0] imm_c;
        logic [31:0] imm_d;
        logic        imm_cd_reference;
    } instr_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] result_value;
        logic [2:0]  result_type;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch instruction
        logic rd_a;       // issue read of src_a
        logic rd_b;       // issue read of src_b, capture a
        logic capture_b;  // capture b, evaluate
        logic div_start;
        logic finish;     // form result, write file
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } dp_status_t;

    // mask a word to the mode width
    function automatic logic [31:0] mask_w(input logic [31:0] x, input logic [2:0] mode);
        case (mode)
            MODE_CHAR:  mask_w = {24'd0, x[7:0]};
            MODE_SHORT: mask_w = {16'd0, x[15:0]};
            default:    mask_w = x;
        endcase
    endfunction

    // sign-extend the mode-width bits to 32
    function automatic logic [31:0] sext_w(input logic [31:0] x, input logic [2:0] mode);
        case (mode)
            MODE_CHAR:  sext_w = {{24{x[7]}}, x[7:0]};
            MODE_SHORT: sext_w = {{16{x[15]}}, x[15:0]};
            default:    sext_w = x;
        endcase
    endfunction

endpackage

`default_nettype wire

/* hdl/tiralu_div.sv */
// ============================================================================
// tiralu_div
// Radix-2 restoring divider, 32 bits, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module tiralu_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient,
    output logic [31:0]      remainder
);

    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= 32'd0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* hdl/tiralu_dp.sv */
// ============================================================================
// tiralu_dp
// Datapath: register file memory, valid bits, operand checks, ALU, divider.
// ============================================================================
`default_nettype none

module tiralu_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tiralu_pkg::instr_t   instr,
    input  wire tiralu_pkg::dp_cmd_t  cmd,
    output tiralu_pkg::dp_status_t    status,
    output tiralu_pkg::result_t       result
);

    localparam int IB = tiralu_pkg::IDX_BITS;

    tiralu_pkg::instr_t ins_reg;
    logic [34:0] mem [tiralu_pkg::NUM_REGS];   // {type, value}
    logic [tiralu_pkg::NUM_REGS-1:0] valid_reg;
    logic [34:0] rd_data_reg;
    logic        rd_ok_reg;
    logic [31:0] a_reg, b_reg;
    logic [2:0]  ta_reg;
    logic        a_ok_reg;
    logic        fail_reg;      // rejected after operand checks
    logic [31:0] r_reg;
    logic [2:0]  t_reg;
    logic        need_div_reg;
    logic        div_neg_q_reg, div_neg_r_reg, div_rem_reg;
    tiralu_pkg::result_t res_reg;

    logic [5:0]  rd_idx;
    logic        rd_in_range;
    logic [5:0]  c;
    logic [2:0]  md;
    logic        is_conv, is_alu, is_choose, imm_only, reg_only;
    logic        early_fail, b_fail;
    logic [31:0] b_val;
    logic [31:0] ua, ub, sa, sb, alu_r, conv_r;
    logic [63:0] prod;
    logic        cmp;
    logic        is_div, swap, sgn_div, div_zero;
    logic [31:0] n_op, d_op, n_abs, d_abs;
    logic        div_done;
    logic [31:0] div_q, div_rm, q_fix, r_fix;
    logic        wr_en;
    logic [5:0]  wr_idx;
    logic [34:0] wr_data;
    logic        clear_all;

    // read port: src_a then src_b
    assign rd_idx      = cmd.rd_a ? ins_reg.src_a : ins_reg.src_b;
    assign rd_in_range = (32'(rd_idx) < tiralu_pkg::NUM_REGS);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            ins_reg <= instr;
        rd_data_reg <= mem[rd_idx[IB-1:0]];
        if (wr_en)
            mem[wr_idx[IB-1:0]] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_ok_reg <= 1'b0;
        else
            rd_ok_reg <= rd_in_range && valid_reg[rd_idx[IB-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (clear_all)
            valid_reg <= '0;
        else if (wr_en)
            valid_reg[wr_idx[IB-1:0]] <= 1'b1;
    end

    // decode
    assign c         = ins_reg.command;
    assign md        = ins_reg.mode;
    assign is_conv   = (c >= tiralu_pkg::CMD_CVTC) && (c <= tiralu_pkg::CMD_CVTUI);
    assign is_alu    = (c <= tiralu_pkg::CMD_SHRU);
    assign is_choose = (c >= tiralu_pkg::CMD_CHE) && (c <= tiralu_pkg::CMD_CHBE);
    assign imm_only  = (c == tiralu_pkg::CMD_SUBR) || (c == tiralu_pkg::CMD_DIVR)
                    || (c == tiralu_pkg::CMD_DIVUR);
    assign reg_only  = (c >= tiralu_pkg::CMD_SHL) && (c <= tiralu_pkg::CMD_SHRU);

    // rejections decided before operands (SET, CLEAR, MOV, LDI handled apart)
    assign early_fail = (c > tiralu_pkg::CMD_CLEAR) || (md == tiralu_pkg::MODE_FLOAT)
                     || (md == tiralu_pkg::MODE_DOUBLE) || (md == tiralu_pkg::MODE_REF)
                     || (is_alu && imm_only && !ins_reg.use_immediate)
                     || (is_alu && reg_only && ins_reg.use_immediate);

    assign b_val  = ins_reg.use_immediate ? ins_reg.imm_b : rd_data_reg[31:0];
    assign b_fail = ins_reg.use_immediate ? (ins_reg.imm_b_type == tiralu_pkg::MODE_REF)
                                          : !rd_ok_reg;

    // ALU on a_reg and b_val
    assign ua   = tiralu_pkg::mask_w(a_reg, md);
    assign ub   = tiralu_pkg::mask_w(b_val, md);
    assign sa   = tiralu_pkg::sext_w(a_reg, md);
    assign sb   = tiralu_pkg::sext_w(b_val, md);
    assign prod = ua * ub;

    always_comb
    begin
        case (c)
            tiralu_pkg::CMD_ADD:  alu_r = ua + ub;
            tiralu_pkg::CMD_SUB:  alu_r = ua - ub;
            tiralu_pkg::CMD_SUBR: alu_r = ub - ua;
            tiralu_pkg::CMD_MUL,
            tiralu_pkg::CMD_MULU: alu_r = prod[31:0];
            tiralu_pkg::CMD_AND:  alu_r = ua & ub;
            tiralu_pkg::CMD_OR:   alu_r = ua | ub;
            tiralu_pkg::CMD_XOR:  alu_r = ua ^ ub;
            tiralu_pkg::CMD_SHL,
            tiralu_pkg::CMD_SHLU: alu_r = ua << b_val[4:0];
            tiralu_pkg::CMD_SHR:  alu_r = 32'($signed(sa) >>> b_val[4:0]);
            default:              alu_r = ua >> b_val[4:0];
        endcase
    end

    always_comb
    begin
        case (c)
            tiralu_pkg::CMD_CVTC:  conv_r = {{24{a_reg[7]}}, a_reg[7:0]};
            tiralu_pkg::CMD_CVTUC: conv_r = {24'd0, a_reg[7:0]};
            tiralu_pkg::CMD_CVTS:  conv_r = {{16{a_reg[15]}}, a_reg[15:0]};
            tiralu_pkg::CMD_CVTUS: conv_r = {16'd0, a_reg[15:0]};
            default:               conv_r = a_reg;
        endcase
    end

    always_comb
    begin
        case (c)
            tiralu_pkg::CMD_CHE:  cmp = (ua == ub);
            tiralu_pkg::CMD_CHL:  cmp = ($signed(sa) < $signed(sb));
            tiralu_pkg::CMD_CHLE: cmp = ($signed(sa) <= $signed(sb));
            tiralu_pkg::CMD_CHB:  cmp = (ua < ub);
            default:              cmp = (ua <= ub);
        endcase
    end

    // division setup: reverse forms swap operands
    assign is_div  = (c >= tiralu_pkg::CMD_DIV) && (c <= tiralu_pkg::CMD_MODU);
    assign swap    = (c == tiralu_pkg::CMD_DIVR) || (c == tiralu_pkg::CMD_DIVUR);
    assign sgn_div = (c == tiralu_pkg::CMD_DIV) || (c == tiralu_pkg::CMD_DIVR)
                  || (c == tiralu_pkg::CMD_MOD);
    assign n_op    = sgn_div ? (swap ? sb : sa) : (swap ? ub : ua);
    assign d_op    = sgn_div ? (swap ? sa : sb) : (swap ? ua : ub);
    assign div_zero = (d_op == 32'd0);
    assign n_abs   = (sgn_div && n_op[31]) ? -n_op : n_op;
    assign d_abs   = (sgn_div && d_op[31]) ? -d_op : d_op;

    tiralu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (n_abs),
        .divisor   (d_abs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_rm)
    );

    assign q_fix = div_neg_q_reg ? -div_q : div_q;
    assign r_fix = div_neg_r_reg ? -div_rm : div_rm;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_b)
        begin
            a_reg  <= rd_data_reg[31:0];
            ta_reg <= rd_data_reg[34:32];
        end
        if (cmd.capture_b)
        begin
            div_neg_q_reg <= sgn_div && (n_op[31] ^ d_op[31]);
            div_neg_r_reg <= sgn_div && n_op[31];
            div_rem_reg   <= (c == tiralu_pkg::CMD_MOD) || (c == tiralu_pkg::CMD_MODU);
            if (is_conv)
                r_reg <= tiralu_pkg::mask_w(conv_r, md);
            else if (c == tiralu_pkg::CMD_NOT)
                r_reg <= tiralu_pkg::mask_w(~a_reg, md);
            else if (is_choose)
                r_reg <= cmp ? ins_reg.imm_c : ins_reg.imm_d;
            else
                r_reg <= tiralu_pkg::mask_w(alu_r, md);
            t_reg <= is_choose ? tiralu_pkg::MODE_INT : md;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ok_reg     <= 1'b0;
            fail_reg     <= 1'b0;
            need_div_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd_b)
                a_ok_reg <= rd_ok_reg;
            if (cmd.capture_b)
            begin
                // converts and NOT need only a
                if (is_conv || (c == tiralu_pkg::CMD_NOT))
                    fail_reg <= early_fail || !a_ok_reg;
                else
                    fail_reg <= early_fail || !a_ok_reg || b_fail
                             || (is_choose && ins_reg.imm_cd_reference)
                             || (is_div && div_zero);
                need_div_reg <= is_div && !early_fail && a_ok_reg && !b_fail && !div_zero;
            end
        end
    end

    assign status.need_div = need_div_reg;
    assign status.div_done = div_done;

    // final write and result
    always_comb
    begin
        wr_en     = 1'b0;
        wr_idx    = ins_reg.dest;
        wr_data   = {t_reg, r_reg};
        clear_all = 1'b0;
        if (cmd.finish)
        begin
            case (c)
                tiralu_pkg::CMD_SET:
                begin
                    wr_en   = 1'b1;
                    wr_data = {ins_reg.imm_b_type, ins_reg.imm_b};
                end
                tiralu_pkg::CMD_CLEAR: clear_all = 1'b1;
                tiralu_pkg::CMD_LDI:
                begin
                    wr_en   = (md != tiralu_pkg::MODE_FLOAT) && (md != tiralu_pkg::MODE_DOUBLE)
                           && (ins_reg.imm_b_type != tiralu_pkg::MODE_REF);
                    wr_data = {ins_reg.imm_b_type, ins_reg.imm_b};
                end
                tiralu_pkg::CMD_MOV:
                begin
                    wr_en   = (md != tiralu_pkg::MODE_FLOAT) && (md != tiralu_pkg::MODE_DOUBLE)
                           && a_ok_reg;
                    wr_data = {ta_reg, a_reg};
                end
                default:
                begin
                    wr_en = !fail_reg;
                    if (need_div_reg)
                        wr_data = {t_reg, tiralu_pkg::mask_w(div_rem_reg ? r_fix : q_fix, md)};
                end
            endcase
            if (32'(ins_reg.dest) >= tiralu_pkg::NUM_REGS)
                wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_reg.ok           <= wr_en || clear_all;
            res_reg.result_value <= wr_en ? wr_data[31:0] : 32'd0;
            res_reg.result_type  <= wr_en ? wr_data[34:32] : 3'd0;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

/* hdl/tiralu_ctrl.sv */
// ============================================================================
// tiralu_ctrl
// Controller: sequences read, evaluate, divide and write; owns handshakes.
// ============================================================================
`default_nettype none

module tiralu_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output tiralu_pkg::dp_cmd_t          cmd,
    input  wire tiralu_pkg::dp_status_t  status
);

    typedef enum logic [2:0] {
        S_IDLE, S_RDA, S_RDB, S_EVAL, S_CHK, S_DIV, S_FIN, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !out_valid_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                cmd.rd_a   = 1'b1;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.rd_b   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.capture_b = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_CHK;
            end
            S_CHK:      state_next = status.need_div ? S_DIV : S_FIN;
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hdl/typed_ir_alu_with_register_file_unit.sv */
// ============================================================================
// typed_ir_alu_with_register_file_unit
// Typed register-file integer ALU: one instruction in, one status beat out.
// ============================================================================
//
//  channel | handshake                | payload
//  --------+--------------------------+---------------------------
//  in      | in_valid / in_ready      | in  (tiralu_pkg::instr_t)
//  out     | out_valid / out_ready    | out (tiralu_pkg::result_t)
//
// out_valid rises once the input beat has been accepted and the controller has
// stepped through load, read src_a, read src_b, evaluate, check and write.
// Divide and modulo also wait in the bit-serial divider before the write.
// The register file is a 64-entry memory with one read port, so src_a and
// src_b are fetched on successive cycles.
// Reset clears all valid bits and the controller; values and types are
// not cleared. One beat is in flight at a time; a new beat is taken the
// cycle after the previous result beat has been accepted.
`default_nettype none

module typed_ir_alu_with_register_file_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tiralu_pkg::instr_t  in,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output tiralu_pkg::result_t      out
);

    tiralu_pkg::dp_cmd_t    cmd;
    tiralu_pkg::dp_status_t status;

    tiralu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    tiralu_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (in),
        .cmd    (cmd),
        .status (status),
        .result (out)
    );

endmodule

`default_nettype wire
